// File: design/nfd_pkg.sv
// shared types, status codes and helpers for the nibble frame decoder
package nfd_pkg;

    // closing status codes, in the encoding seen on the status port
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_LEN_MISMATCH = 2'd1,
        ST_CHK_MISMATCH = 2'd2,
        ST_PARITY_ERR   = 2'd3
    } t_status;

    // header field masks
    localparam logic [7:0] CMD_MASK = 8'h07;
    localparam logic [7:0] LEN_MASK = 8'hF8;
    localparam logic [7:0] NIB_MASK = 8'h0F;

    localparam int unsigned POS_W = 10;
    localparam int unsigned LEN_W = 9;
    localparam int unsigned CHK_W = 12;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // one received byte with its side flags
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
        logic       parity_bad;
    } t_item;

    // one result as it leaves the decode stage
    typedef struct packed {
        logic [7:0]       data_byte;
        logic             has_data;
        logic             frame_done;
        t_status          status;
        logic [2:0]       command;
        logic [LEN_W-1:0] payload_length;
    } t_result;

    // number of set bits in a byte
    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int k = 0; k < 8; k++) begin
            c = c + {3'd0, v[k]};
        end
        return c;
    endfunction

endpackage

// File: design/nfd_core.sv
// frame state and combinational decode of one byte
module nfd_core
    import nfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result,
    output logic    o_emit
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] r_len, n_len;
    logic [2:0]       r_cmd, n_cmd;
    logic [3:0]       r_prev, n_prev;
    logic [CHK_W-1:0] r_bits, n_bits;
    logic [3:0]       r_rx_low, n_rx_low;
    logic             r_par, n_par;

    logic [7:0]       b;
    logic [POS_W-1:0] len_ext;
    logic [POS_W-1:0] len_p1;
    logic [POS_W-1:0] len_p2;
    logic [CHK_W-1:0] rx_chk;
    logic             check_ok;
    logic             has;

    // decode of the byte at the current position
    always_comb begin
        b        = i_item.frame_byte;
        n_par    = r_par | i_item.parity_bad;
        n_cmd    = r_cmd;
        n_len    = r_len;
        n_prev   = r_prev;
        n_bits   = r_bits;
        n_rx_low = r_rx_low;
        check_ok = 1'b0;
        has      = 1'b0;
        rx_chk   = {b, r_rx_low};

        if (r_pos == '0) begin
            n_cmd  = b[2:0] & CMD_MASK[2:0];
            n_len  = {4'd0, 5'((b & LEN_MASK) >> 3)};
            n_bits = r_bits + {8'd0, ones8(b)};
        end else if (r_pos == POS_W'(1)) begin
            n_len = {b[3:0] & NIB_MASK[3:0], r_len[4:0]};
        end

        len_ext = {1'b0, n_len};
        len_p1  = len_ext + POS_W'(1);
        len_p2  = len_ext + POS_W'(2);

        if (r_pos != '0) begin
            has = (r_pos >= POS_W'(2)) && (r_pos <= len_p1);
            if (r_pos <= len_ext) begin
                n_bits = r_bits + {8'd0, ones8(b)};
                n_prev = b[7:4];
            end else if (r_pos == len_p1) begin
                n_bits   = r_bits + {8'd0, ones8(b & NIB_MASK)};
                n_rx_low = b[7:4];
            end else if (r_pos == len_p2) begin
                check_ok = (rx_chk == r_bits);
            end
        end

        // result assembly
        o_result.data_byte      = has ? {b[3:0], r_prev} : 8'd0;
        o_result.has_data       = has;
        o_result.frame_done     = i_item.is_last;
        o_result.command        = n_cmd;
        o_result.payload_length = n_len;
        if (!i_item.is_last) begin
            o_result.status = ST_OK;
        end else if (n_par) begin
            o_result.status = ST_PARITY_ERR;
        end else if (r_pos != len_p2) begin
            o_result.status = ST_LEN_MISMATCH;
        end else if (!check_ok) begin
            o_result.status = ST_CHK_MISMATCH;
        end else begin
            o_result.status = ST_OK;
        end
        o_emit = has | i_item.is_last;

        // position advance, frame end clears everything
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + POS_W'(1);
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_cmd    <= '0;
            r_prev   <= '0;
            r_bits   <= '0;
            r_rx_low <= '0;
            r_par    <= 1'b0;
        end else if (i_fire) begin
            if (i_item.is_last) begin
                r_pos    <= '0;
                r_len    <= '0;
                r_cmd    <= '0;
                r_prev   <= '0;
                r_bits   <= '0;
                r_rx_low <= '0;
                r_par    <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_len    <= n_len;
                r_cmd    <= n_cmd;
                r_prev   <= n_prev;
                r_bits   <= n_bits;
                r_rx_low <= n_rx_low;
                r_par    <= n_par;
            end
        end
    end

endmodule

// File: design/nibble_frame_decoder_top.sv
// top level: input register, decode stage and result register
// Decodes received frame bytes at one byte per clock cycle while the input is not
// stalled. Each accepted byte is registered and decoded against the frame state in
// the following cycle. When it completes a data byte or closes the frame, its result
// is placed in the result register as the decode stage advances. The rate is set by
// the single frame-state update per byte in the decode stage. Bytes keep flowing
// while a result waits. Input stalls only when the result register is full and
// stalled and the waiting byte would produce a result. The status is reported on the
// byte marked last, after which the decoder is ready for the next frame's header.
module nibble_frame_decoder_top
    import nfd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_frame_byte,
    input  logic             i_is_last,
    input  logic             i_parity_bad,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_data_byte,
    output logic             o_has_data,
    output logic             o_frame_done,
    output logic [1:0]       o_status,
    output logic [2:0]       o_command,
    output logic [LEN_W-1:0] o_payload_length
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result core_result;
    logic    core_emit;
    logic    advance;
    logic    in_accept;

    // decode stage moves on unless its result has nowhere to go
    assign advance    = r_in_valid && (!core_emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.frame_byte <= i_frame_byte;
            r_item.is_last    <= i_is_last;
            r_item.parity_bad <= i_parity_bad;
        end
    end

    nfd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .o_result (core_result),
        .o_emit   (core_emit)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && core_emit) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_data_byte      = r_result.data_byte;
    assign o_has_data       = r_result.has_data;
    assign o_frame_done     = r_result.frame_done;
    assign o_status         = r_result.status;
    assign o_command        = r_result.command;
    assign o_payload_length = r_result.payload_length;

    // a transaction on the output always carries data or a frame close
    a_out_meaningful: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_has_data || o_frame_done))
        else $error("result without data or frame close");

    // status is ok unless the frame closes
    a_status_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_done) |-> (o_status == ST_OK))
        else $error("status set on a result that does not close a frame");

    // input stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled without a blocked result");

    // a byte that produces a result lands in the result register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && core_emit) |=> (r_out_valid && (o_frame_done == $past(r_item.is_last))))
        else $error("decoded result not captured");

endmodule

// File: sim/nibble_frame_decoder_top_test.sv
// testbench for the nibble frame decoder: directed table, random frames, scoreboard
`timescale 1ns / 100ps

module nibble_frame_decoder_top_test;
    import nfd_pkg::*;

    // one expected result transaction
    typedef struct {
        logic [7:0]       data_byte;
        logic             has_data;
        logic             frame_done;
        t_status          status;
        logic [2:0]       command;
        logic [LEN_W-1:0] payload_length;
    } t_frame_out;

    // one row of the directed table
    typedef struct {
        t_item      item;
        bit         typed;
        t_frame_out want;
    } t_stim_row;

    // shapes of generated frames
    typedef enum int {
        FR_GOOD,
        FR_BAD_CHK,
        FR_SHORT,
        FR_LONG,
        FR_PARITY,
        FR_NOISE
    } t_frame_kind;

    localparam int RANDOM_ITEMS = 470;
    localparam int MAX_LEN      = 40;
    localparam int DRAIN_CYCLES = 8;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [7:0]       i_frame_byte = 8'd0;
    logic             i_is_last = 1'b0;
    logic             i_parity_bad = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [7:0]       o_data_byte;
    logic             o_has_data;
    logic             o_frame_done;
    logic [1:0]       o_status;
    logic [2:0]       o_command;
    logic [LEN_W-1:0] o_payload_length;

    nibble_frame_decoder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_frame_byte     (i_frame_byte),
        .i_is_last        (i_is_last),
        .i_parity_bad     (i_parity_bad),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_data_byte      (o_data_byte),
        .o_has_data       (o_has_data),
        .o_frame_done     (o_frame_done),
        .o_status         (o_status),
        .o_command        (o_command),
        .o_payload_length (o_payload_length)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder state as the testbench tracks it
    logic [POS_W-1:0] pos_r;
    logic [LEN_W-1:0] len_r;
    logic [2:0]       cmd_r;
    logic [3:0]       prev_nib_r;
    logic [CHK_W-1:0] bits_r;
    logic [3:0]       chk_lo_r;
    logic             par_seen_r;

    t_frame_out  pending_results [$];
    t_stim_row   stim_tab [$];
    logic [7:0]  fb_buf [0:MAX_LEN+7];
    logic        par_buf [0:MAX_LEN+7];
    int          fb_count;
    int          mismatch_count = 0;
    bit          quiet = 1'b0;
    bit          drain = 1'b0;
    int          stall_left = 0;
    int          stall_roll;

    function automatic logic [3:0] count_ones(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + 4'(v[k]);
        end
        return n;
    endfunction

    task automatic clear_frame_state();
        pos_r      = '0;
        len_r      = '0;
        cmd_r      = '0;
        prev_nib_r = '0;
        bits_r     = '0;
        chk_lo_r   = '0;
        par_seen_r = 1'b0;
    endtask

    // advance the frame state by one byte and form the result it causes
    task automatic decode_byte(input t_item it, output bit emits, output t_frame_out r);
        int         p;
        int         lenw;
        logic [7:0] fb;
        logic [11:0] rx;
        bit         chk_ok;
        p = int'(pos_r);
        fb = it.frame_byte;
        chk_ok = 1'b0;
        r.data_byte  = 8'd0;
        r.has_data   = 1'b0;
        r.frame_done = 1'b0;
        r.status     = ST_OK;
        par_seen_r   = par_seen_r | it.parity_bad;

        if (p == 0) begin
            cmd_r  = fb[2:0];
            len_r  = {4'd0, fb[7:3]};
            bits_r = bits_r + 12'(count_ones(fb));
        end else begin
            if (p == 1)
                len_r = {fb[3:0], len_r[4:0]};
            lenw = int'(len_r);
            if (p >= 2 && p <= lenw + 1) begin
                r.data_byte = {fb[3:0], prev_nib_r};
                r.has_data  = 1'b1;
            end
            if (p <= lenw) begin
                bits_r     = bits_r + 12'(count_ones(fb));
                prev_nib_r = fb[7:4];
            end else if (p == lenw + 1) begin
                bits_r   = bits_r + 12'(count_ones(fb & NIB_MASK));
                chk_lo_r = fb[7:4];
            end else if (p == lenw + 2) begin
                rx     = {fb, chk_lo_r};
                chk_ok = (rx == bits_r);
            end
        end

        // closing status, parity first
        if (it.is_last) begin
            r.frame_done = 1'b1;
            if (par_seen_r)
                r.status = ST_PARITY_ERR;
            else if (p != int'(len_r) + 2)
                r.status = ST_LEN_MISMATCH;
            else if (!chk_ok)
                r.status = ST_CHK_MISMATCH;
            else
                r.status = ST_OK;
        end
        r.command        = cmd_r;
        r.payload_length = len_r;
        emits = r.has_data || r.frame_done;

        if (it.is_last)
            clear_frame_state();
        else if (pos_r != POS_MAX)
            pos_r = pos_r + 1'b1;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // compare one accepted result transaction with the oldest expectation
    task automatic check_result_beat();
        t_frame_out w;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected");
        end else begin
            w = pending_results.pop_front();
            if (o_data_byte !== w.data_byte)
                report_mismatch($sformatf("data_byte %h want %h", o_data_byte, w.data_byte));
            if (o_has_data !== w.has_data)
                report_mismatch($sformatf("has_data %b want %b", o_has_data, w.has_data));
            if (o_frame_done !== w.frame_done)
                report_mismatch($sformatf("frame_done %b want %b", o_frame_done, w.frame_done));
            if (o_status !== w.status)
                report_mismatch($sformatf("status %0d want %0d", o_status, w.status));
            if (o_command !== w.command)
                report_mismatch($sformatf("command %0d want %0d", o_command, w.command));
            if (o_payload_length !== w.payload_length)
                report_mismatch($sformatf("payload_length %0d want %0d",
                                          o_payload_length, w.payload_length));
        end
    endtask

    // output side: check accepted results, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result_beat();
        if (drain || quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70) begin
                i_out_stall <= 1'b0;
            end else if (stall_roll < 95) begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left  <= $urandom_range(5, 25);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 65)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // drive one byte transaction and record what it should produce
    task automatic send_item(input t_item it, input bit typed, input t_frame_out want);
        bit         emits;
        t_frame_out got_r;
        int         gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_frame_byte <= it.frame_byte;
        i_is_last    <= it.is_last;
        i_parity_bad <= it.parity_bad;
        do @(posedge i_clk); while (o_in_stall);
        decode_byte(it, emits, got_r);
        if (typed)
            pending_results.push_back(want);
        else if (emits)
            pending_results.push_back(got_r);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_plain(input logic [7:0] fb, input bit last, input bit par);
        t_stim_row row;
        row.item  = '{frame_byte: fb, is_last: last, parity_bad: par};
        row.typed = 1'b0;
        row.want  = '{8'd0, 1'b0, 1'b0, ST_OK, 3'd0, 9'd0};
        stim_tab.push_back(row);
    endtask

    // closing byte whose status can be read off directly
    task automatic add_closing(input logic [7:0] fb, input bit par, input t_status st,
                               input logic [2:0] cmd, input logic [LEN_W-1:0] len);
        t_stim_row row;
        row.item  = '{frame_byte: fb, is_last: 1'b1, parity_bad: par};
        row.typed = 1'b1;
        row.want  = '{8'd0, 1'b0, 1'b1, st, cmd, len};
        stim_tab.push_back(row);
    endtask

    // fill fb_buf with one frame of the given shape
    task automatic build_frame(input int len, input t_frame_kind kind);
        logic [8:0]  lv;
        logic [11:0] chk;
        int          k;
        int          flip;
        int          par_at;
        lv = 9'(len);
        if (kind == FR_NOISE) begin
            fb_count = $urandom_range(1, 6);
            for (k = 0; k < fb_count; k++) begin
                fb_buf[k]  = 8'($urandom);
                par_buf[k] = ($urandom_range(0, 7) == 0);
            end
        end else begin
            // header, random payload nibbles, then a matching checksum
            fb_count = len + 3;
            fb_buf[0] = {lv[4:0], 3'($urandom)};
            for (k = 1; k < fb_count; k++)
                fb_buf[k] = 8'($urandom);
            fb_buf[1] = {fb_buf[1][7:4], lv[8:5]};
            chk = 12'd0;
            for (k = 0; k <= len; k++)
                chk = chk + 12'(count_ones(fb_buf[k]));
            chk = chk + 12'(count_ones(fb_buf[len+1] & NIB_MASK));
            fb_buf[len+1] = {chk[3:0], fb_buf[len+1][3:0]};
            fb_buf[len+2] = chk[11:4];
            for (k = 0; k < fb_count; k++)
                par_buf[k] = 1'b0;

            case (kind)
                FR_BAD_CHK: begin
                    flip = $urandom_range(0, 11);
                    if (flip < 4)
                        fb_buf[len+1][4+flip] = ~fb_buf[len+1][4+flip];
                    else
                        fb_buf[len+2][flip-4] = ~fb_buf[len+2][flip-4];
                end
                FR_SHORT: fb_count = $urandom_range(1, len + 2);
                FR_LONG: begin
                    repeat ($urandom_range(1, 4)) begin
                        fb_buf[fb_count]  = 8'($urandom);
                        par_buf[fb_count] = 1'b0;
                        fb_count++;
                    end
                end
                FR_PARITY: begin
                    par_at = $urandom_range(0, fb_count - 1);
                    par_buf[par_at] = 1'b1;
                end
                default: ;
            endcase
        end
    endtask

    task automatic send_frame();
        t_item      it;
        t_frame_out none;
        none = '{8'd0, 1'b0, 1'b0, ST_OK, 3'd0, 9'd0};
        for (int k = 0; k < fb_count; k++) begin
            it.frame_byte = fb_buf[k];
            it.is_last    = (k == fb_count - 1);
            it.parity_bad = par_buf[k];
            send_item(it, 1'b0, none);
        end
    endtask

    // stimulus
    initial begin
        int          sent;
        int          frames;
        int          roll;
        int          len;
        t_frame_kind kind;
        clear_frame_state();

        // frame ending on its header byte, all ones and all zeros
        add_closing(8'hFF, 1'b0, ST_LEN_MISMATCH, 3'd7, 9'd31);
        add_closing(8'h00, 1'b1, ST_PARITY_ERR, 3'd0, 9'd0);
        // zero length frame, good checksum
        add_plain(8'h05, 1'b0, 1'b0);
        add_plain(8'h20, 1'b0, 1'b0);
        add_closing(8'h00, 1'b0, ST_OK, 3'd5, 9'd0);
        // zero length frame, checksum off by one bit
        add_plain(8'h05, 1'b0, 1'b0);
        add_plain(8'h20, 1'b0, 1'b0);
        add_closing(8'h01, 1'b0, ST_CHK_MISMATCH, 3'd5, 9'd0);
        // frame ending on the second header byte
        add_plain(8'h05, 1'b0, 1'b0);
        add_closing(8'h20, 1'b0, ST_LEN_MISMATCH, 3'd5, 9'd0);
        // frame with a trailing extra byte
        add_plain(8'h05, 1'b0, 1'b0);
        add_plain(8'h20, 1'b0, 1'b0);
        add_plain(8'h00, 1'b0, 1'b0);
        add_closing(8'hAB, 1'b0, ST_LEN_MISMATCH, 3'd5, 9'd0);
        // two data bytes, good checksum
        add_plain(8'h13, 1'b0, 1'b0);
        add_plain(8'hA0, 1'b0, 1'b0);
        add_plain(8'h5C, 1'b0, 1'b0);
        add_plain(8'hC7, 1'b0, 1'b0);
        add_closing(8'h00, 1'b0, ST_OK, 3'd3, 9'd2);
        // last byte carries data and status together
        add_plain(8'h0B, 1'b0, 1'b0);
        add_plain(8'h30, 1'b0, 1'b0);
        add_plain(8'h4D, 1'b1, 1'b0);
        // parity flagged mid frame wins over a good checksum
        add_plain(8'h05, 1'b0, 1'b0);
        add_plain(8'h20, 1'b0, 1'b1);
        add_closing(8'h00, 1'b0, ST_PARITY_ERR, 3'd5, 9'd0);
        // maximum length header cut short
        add_plain(8'hFA, 1'b0, 1'b0);
        add_plain(8'hFF, 1'b0, 1'b0);
        add_plain(8'h00, 1'b1, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_tab[n])
            send_item(stim_tab[n].item, stim_tab[n].typed, stim_tab[n].want);
        wait_results_drained();

        // random frames, mostly well formed
        sent = 0;
        frames = 0;
        while (sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 65)      kind = FR_GOOD;
            else if (roll < 73) kind = FR_BAD_CHK;
            else if (roll < 80) kind = FR_SHORT;
            else if (roll < 86) kind = FR_LONG;
            else if (roll < 92) kind = FR_PARITY;
            else                kind = FR_NOISE;
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
                                               : $urandom_range(7, MAX_LEN);
            quiet = ($urandom_range(0, 7) == 0);
            build_frame(len, kind);
            send_frame();
            sent += fb_count;
            frames++;
            if (frames == 30)
                wait_results_drained();
        end
        quiet = 1'b0;

        wait_results_drained();
        drain = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[nibble_frame_decoder_top] OK");
        else
            $display("[nibble_frame_decoder_top] ERROR");
        $finish;
    end

    // run time limit
    initial begin
        #10_000_000;
        $display("[nibble_frame_decoder_top] ERROR");
        $finish;
    end

endmodule
